### rtl/core/aeb_pkg.sv
// Package for the adaptive execution budget unit.
// Holds the sequencer state type, configuration register indexes and reset values.
// No dependencies.
package aeb_pkg;

    // Width of the configuration register index on the write port.
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_NUM  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_COST = 3'd3;

    localparam logic [7:0]  NUM_RESET  = 8'd3;
    localparam logic [7:0]  DEN_RESET  = 8'd4;
    localparam logic [31:0] CAP_RESET  = 32'd65536;
    localparam logic [15:0] COST_RESET = 16'd1000;

    // Dividend width of the shared divider: the usable time saturates at 64 bits.
    localparam int DVD_W = 64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OBS,
        ST_SDIV,
        ST_CLAMP_LO,
        ST_CLAMP_HI,
        ST_GAP,
        ST_UPDATE,
        ST_QSTART,
        ST_QDIV,
        ST_MUL,
        ST_BSTART,
        ST_BDIV,
        ST_CAP,
        ST_DONE
    } aeb_state_t;

endpackage

### rtl/core/aeb_divider.sv
// Shared restoring divider: one quotient bit per cycle.
// Short operations pre-align a SHORT_W-bit dividend to save cycles.
// Depends on nothing.
module aeb_divider #(
    parameter int DVD_W   = 64,
    parameter int DVS_W   = 40,
    parameter int SHORT_W = 40
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic             short_op,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DVS_W:0]   rem_shift;
    logic [DVS_W+1:0] diff;
    logic             fits;

    assign rem_shift = {rem_reg, quo_reg[DVD_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, dvs_reg};
    assign fits      = ~diff[DVS_W+1];

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = short_op ? (dividend << (DVD_W - SHORT_W)) : dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = short_op ? CNT_W'(SHORT_W) : CNT_W'(DVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DVD_W-2:0], fits};
            rem_next = fits ? diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/core/adaptive_execution_budget_unit.sv
// Top level of the adaptive execution budget unit: sequencer, estimate and budget datapath.
// Depends on aeb_pkg and aeb_divider.
//
// The unit keeps a per-block cost estimate and turns each item into one budget result. The
// work is three divisions run one after another on one bit-serial divider, one quotient bit
// per cycle: TIME_BITS quotient bits for the sample and for the target fraction, and 64 bits
// for the budget itself. An item without an observation skips the sample division and the
// estimate update. A zero target skips the fraction and budget divisions. s_ready is high
// only while the unit is idle. A finished budget waits in the output register, and the next
// item may be taken meanwhile. Writing the cost register also reloads the estimate; writes
// are to be made by the user only while idle, and the unit itself does not enforce this.
module adaptive_execution_budget_unit
    import aeb_pkg::*;
#(
    parameter int TIME_BITS = 40,
    localparam int CfgW = (TIME_BITS > 32) ? TIME_BITS : 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [31:0]          s_blocks_done,
    input  logic [TIME_BITS-1:0] s_elapsed_ns,
    input  logic [TIME_BITS-1:0] s_target_ns,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [31:0]          m_budget,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CfgW-1:0]      cfg_wdata
);

    localparam int TB    = TIME_BITS;
    localparam int SW    = TIME_BITS + 3;
    localparam int PW    = TIME_BITS + 8;
    localparam int DVS_W = (TIME_BITS > 32) ? TIME_BITS : 32;

    aeb_state_t state_reg, state_next;

    logic [7:0]       num_reg, num_next;
    logic [7:0]       den_reg, den_next;
    logic [31:0]      cap_reg, cap_next;
    logic [TB-1:0]    est_reg, est_next;
    logic [31:0]      blocks_reg, blocks_next;
    logic [TB-1:0]    elapsed_reg, elapsed_next;
    logic [TB-1:0]    target_reg, target_next;
    logic [SW-1:0]    samp_reg, samp_next;
    logic [SW-1:0]    gap_reg, gap_next;
    logic             up_reg, up_next;
    logic [DVD_W-1:0] usable_reg, usable_next;
    logic [31:0]      budget_reg, budget_next;
    logic [31:0]      m_budget_reg, m_budget_next;
    logic             m_valid_reg, m_valid_next;

    logic             div_start;
    logic             div_short;
    logic [DVD_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    logic             div_done;
    logic [DVD_W-1:0] div_quo;

    logic             observe;
    logic [TB-1:0]    lower_raw;
    logic [SW-1:0]    lower_ext;
    logic [SW-1:0]    upper_ext;
    logic [SW-1:0]    est_ext;
    logic [SW-1:0]    upd;
    logic [TB-1:0]    cost_wr;
    logic [PW-1:0]    prod;
    logic [DVD_W-1:0] usable_sat;
    logic [31:0]      capped;
    logic             out_free;

    aeb_divider #(
        .DVD_W   (DVD_W),
        .DVS_W   (DVS_W),
        .SHORT_W (TB)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .short_op (div_short),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign observe   = (blocks_reg != '0) && (elapsed_reg != '0);
    assign lower_raw = est_reg >> 3;
    assign lower_ext = (lower_raw == '0) ? SW'(1) : SW'(lower_raw);
    assign upper_ext = {est_reg, 3'b000};
    assign est_ext   = SW'(est_reg);
    // Rise by half the gap rounded up (gap already holds the +1), fall by a quarter.
    assign upd       = up_reg ? (est_ext + (gap_reg >> 1)) : (est_ext - (gap_reg >> 2));
    assign cost_wr   = (cfg_wdata[TB-1:0] == '0) ? TB'(1) : cfg_wdata[TB-1:0];
    assign prod      = PW'(div_quo[TB-1:0]) * PW'(num_reg);
    assign usable_sat = (|(prod >> DVD_W)) ? '1 : DVD_W'(prod);
    // A zero cap is checked first and gives zero; only then does the floor of one block apply.
    assign capped    = (cap_reg == '0) ? 32'd0 :
                       (div_quo == '0) ? 32'd1 :
                       (div_quo > DVD_W'(cap_reg)) ? cap_reg : div_quo[31:0];
    assign out_free  = !m_valid_reg || m_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_valid) state_next = ST_OBS;
            ST_OBS:      state_next = observe ? ST_SDIV : ST_QSTART;
            ST_SDIV:     if (div_done) state_next = ST_CLAMP_LO;
            ST_CLAMP_LO: state_next = ST_CLAMP_HI;
            ST_CLAMP_HI: state_next = ST_GAP;
            ST_GAP:      state_next = ST_UPDATE;
            ST_UPDATE:   state_next = ST_QSTART;
            ST_QSTART:   state_next = (target_reg == '0) ? ST_DONE : ST_QDIV;
            ST_QDIV:     if (div_done) state_next = ST_MUL;
            ST_MUL:      state_next = ST_BSTART;
            ST_BSTART:   state_next = ST_BDIV;
            ST_BDIV:     if (div_done) state_next = ST_CAP;
            ST_CAP:      state_next = ST_DONE;
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and divider requests.
    always_comb begin
        s_ready      = 1'b0;
        div_start    = 1'b0;
        div_short    = 1'b1;
        div_dividend = DVD_W'(elapsed_reg);
        div_divisor  = DVS_W'(blocks_reg);
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_OBS: begin
                div_start = observe;
            end
            ST_QSTART: begin
                div_start    = (target_reg != '0);
                div_dividend = DVD_W'(target_reg);
                div_divisor  = (den_reg == '0) ? DVS_W'(1) : DVS_W'(den_reg);
            end
            ST_BSTART: begin
                div_start    = 1'b1;
                div_short    = 1'b0;
                div_dividend = usable_reg;
                div_divisor  = DVS_W'(est_reg);
            end
            default: begin
            end
        endcase
    end

    // Datapath and configuration registers.
    always_comb begin
        num_next      = num_reg;
        den_next      = den_reg;
        cap_next      = cap_reg;
        est_next      = est_reg;
        blocks_next   = blocks_reg;
        elapsed_next  = elapsed_reg;
        target_next   = target_reg;
        samp_next     = samp_reg;
        gap_next      = gap_reg;
        up_next       = up_reg;
        usable_next   = usable_reg;
        budget_next   = budget_reg;
        m_budget_next = m_budget_reg;
        m_valid_next  = m_valid_reg && !m_ready;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    blocks_next  = s_blocks_done;
                    elapsed_next = s_elapsed_ns;
                    target_next  = s_target_ns;
                end
            end
            ST_SDIV: begin
                if (div_done) samp_next = SW'(div_quo[TB-1:0]);
            end
            ST_CLAMP_LO: begin
                if (samp_reg < lower_ext) samp_next = lower_ext;
            end
            ST_CLAMP_HI: begin
                if (samp_reg > upper_ext) samp_next = upper_ext;
            end
            ST_GAP: begin
                up_next  = (samp_reg > est_ext);
                gap_next = (samp_reg > est_ext) ? (samp_reg - est_ext + SW'(1))
                                                : (est_ext - samp_reg);
            end
            ST_UPDATE: begin
                est_next = (upd[TB-1:0] == '0) ? TB'(1) : upd[TB-1:0];
            end
            ST_QSTART: begin
                budget_next = '0;
            end
            ST_MUL: begin
                usable_next = usable_sat;
            end
            ST_CAP: begin
                budget_next = capped;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_budget_next = budget_reg;
                    m_valid_next  = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_IDX_NUM:  num_next = cfg_wdata[7:0];
                CFG_IDX_DEN:  den_next = cfg_wdata[7:0];
                CFG_IDX_CAP:  cap_next = cfg_wdata[31:0];
                CFG_IDX_COST: est_next = cost_wr;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            num_reg     <= NUM_RESET;
            den_reg     <= DEN_RESET;
            cap_reg     <= CAP_RESET;
            est_reg     <= TB'(COST_RESET);
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            num_reg     <= num_next;
            den_reg     <= den_next;
            cap_reg     <= cap_next;
            est_reg     <= est_next;
        end
    end

    always_ff @(posedge aclk) begin
        blocks_reg   <= blocks_next;
        elapsed_reg  <= elapsed_next;
        target_reg   <= target_next;
        samp_reg     <= samp_next;
        gap_reg      <= gap_next;
        up_reg       <= up_next;
        usable_reg   <= usable_next;
        budget_reg   <= budget_next;
        m_budget_reg <= m_budget_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_budget = m_budget_reg;

endmodule

### rtl/core/aeb_checker.sv
// Port-level checks for the adaptive execution budget unit, bound to its top level.
// Depends on adaptive_execution_budget_unit.
module aeb_checker #(
    parameter int TIME_BITS = 40
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_budget
);

    // The unit comes out of reset idle and with no result pending.
    a_reset_idle: assert property (@(posedge aclk)
        $past(!aresetn) && aresetn |-> s_ready && !m_valid)
        else $error("unit not idle after reset");

    // The unit is not ready again in the cycle after it accepts an item.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready after accepting an item");

    // A new result only appears at the end of an item's work, never while idle.
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without an item in work");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_budget))
        else $error("stalled result changed");

endmodule

bind adaptive_execution_budget_unit aeb_checker #(.TIME_BITS(TIME_BITS)) u_aeb_checker (.*);
